// ----- rtl/sat_pkg.sv -----
// Shared types and codes for the session admission table.
`default_nettype none

package sat_pkg;

    typedef logic [2:0] op_t;
    typedef logic [2:0] rc_t;

    localparam op_t OP_CLEAR  = 3'd0;
    localparam op_t OP_ADD    = 3'd1;
    localparam op_t OP_BEGIN  = 3'd2;
    localparam op_t OP_REPORT = 3'd3;
    localparam op_t OP_TICK   = 3'd4;
    localparam op_t OP_CANCEL = 3'd5;
    localparam op_t OP_REMOVE = 3'd6;

    localparam rc_t RC_OK      = 3'd0;
    localparam rc_t RC_WINDOW  = 3'd1;
    localparam rc_t RC_UNKNOWN = 3'd2;
    localparam rc_t RC_DUP     = 3'd3;
    localparam rc_t RC_FULL    = 3'd4;
    localparam rc_t RC_BADIDX  = 3'd5;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_CODE = 8'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd8;
    localparam logic [7:0]  ACCEPT_RESET  = 8'd0;

    typedef struct packed {
        op_t         op;
        logic [63:0] node_iid;
        logic [7:0]  report_status;
        logic [5:0]  entry_index;
    } sat_req_t;

    typedef struct packed {
        rc_t        result_code;
        logic [6:0] member_count;
        logic       window_open;
        logic       admission_done;
        logic [6:0] accepted_total;
        logic [6:0] rejected_total;
        logic [6:0] silent_total;
        logic       table_empty;
        logic [5:0] match_index;
    } sat_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIND,
        ST_SHIFT,
        ST_COMPACT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/session_admission_table_core.sv -----
// Top level: request/response handshake, config registers and response register.
// Steps: every request passes through EXEC and FINISH; an open-window report walks one entry
// per cycle in FIND, a close (by report or tick) adds a COMPACT walk over the table, and a
// good remove shifts the entries above the index down in SHIFT. FINISH waits for a free output.
// Throughput: one item at a time; no new request is taken until the block is back in IDLE.
// Reset: async active low; table empty, window closed, config back to 8 ticks / code 0.
`default_nettype none

module session_admission_table_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire sat_pkg::sat_req_t                 req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output sat_pkg::sat_rsp_t                      rsp,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sat_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [15:0]       timeout_reg;
    logic [7:0]        accept_code_reg;
    logic              rsp_valid_reg;
    sat_pkg::sat_rsp_t rsp_reg;
    logic              idle;
    logic              out_free;
    logic              res_valid;
    sat_pkg::sat_rsp_t res;

    assign cfg_ready = 1'b1;
    assign req_ready = idle;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sat_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (req_valid && idle),
        .item          (req),
        .out_free      (out_free),
        .timeout_ticks (timeout_reg),
        .accepted_code (accept_code_reg),
        .idle          (idle),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= sat_pkg::TIMEOUT_RESET;
            accept_code_reg <= sat_pkg::ACCEPT_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sat_pkg::CFG_TIMEOUT)
                begin
                    timeout_reg <= cfg_data;
                end
                else if (cfg_index == sat_pkg::CFG_ACCEPT_CODE)
                begin
                    accept_code_reg <= cfg_data[7:0];
                end
            end
            if (res_valid)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the response until its transfer completes.
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sat_id_ram.sv -----
// Member identifier store: one write port, one registered read port.
`default_nettype none

module sat_id_ram #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [63:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [63:0]   rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/sat_ctrl.sv -----
// Sequencer, table state and entry walker for the session admission table.
`default_nettype none

module sat_ctrl #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire sat_pkg::sat_req_t item,
    input  wire logic             out_free,
    input  wire logic [15:0]      timeout_ticks,
    input  wire logic [7:0]       accepted_code,
    output logic                  idle,
    output logic                  res_valid,
    output sat_pkg::sat_rsp_t     res
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    sat_pkg::state_t state_reg, state_next;

    sat_pkg::op_t     op_reg, op_next;
    logic [63:0]      iid_reg, iid_next;
    logic [7:0]       status_reg, status_next;
    logic [5:0]       idx_reg, idx_next;

    logic [CW-1:0]          count_reg, count_next;
    logic                   window_reg, window_next;
    logic [15:0]            countdown_reg, countdown_next;
    logic [MAX_ENTRIES-1:0] replied_reg, replied_next;
    logic [MAX_ENTRIES-1:0] accepted_reg, accepted_next;

    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    wptr_reg, wptr_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    proc_reg, proc_next;
    logic [CW-1:0]    acc_reg, acc_next;
    logic [CW-1:0]    rej_reg, rej_next;
    logic [CW-1:0]    sil_reg, sil_next;
    sat_pkg::rc_t     rc_reg, rc_next;
    logic [AW-1:0]    match_reg, match_next;
    logic             done_reg, done_next;
    logic             empty_reg, empty_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [63:0]      ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [63:0]      ram_rdata;

    logic [MAX_ENTRIES-1:0] valid_mask;
    logic [MAX_ENTRIES-1:0] keep_mask;
    logic [MAX_ENTRIES-1:0] hit_bit;
    logic [MAX_ENTRIES-1:0] rep_shift;
    logic [MAX_ENTRIES-1:0] acc_shift;
    logic [15:0]            cd_dec;
    logic [CW-1:0]          idx_cw;
    logic                   bad_idx;
    logic                   issue;
    logic                   walk_end;
    logic                   hit;
    logic                   all_answered;

    sat_id_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            valid_mask[j] = CW'(j) < count_reg;
            keep_mask[j]  = CW'(j) < wptr_reg;
            hit_bit[j]    = AW'(j) == proc_reg;
        end
    end

    assign cd_dec       = (countdown_reg == '0) ? '0 : countdown_reg - 16'd1;
    assign idx_cw       = CW'(idx_reg);
    assign bad_idx      = {1'b0, idx_reg} >= 7'(count_reg);
    assign issue        = ptr_reg < count_reg;
    assign walk_end     = (ptr_reg == count_reg) && !pend_reg;
    assign hit          = pend_reg && (ram_rdata == iid_reg);
    assign all_answered = &(replied_reg | hit_bit | ~valid_mask);
    assign rep_shift    = replied_reg >> 1;
    assign acc_shift    = accepted_reg >> 1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sat_pkg::ST_EXEC;
                end
            end
            sat_pkg::ST_EXEC:
            begin
                case (op_reg)
                    sat_pkg::OP_REPORT:
                    begin
                        state_next = (window_reg && count_reg != '0) ?
                                     sat_pkg::ST_FIND : sat_pkg::ST_FINISH;
                    end
                    sat_pkg::OP_TICK:
                    begin
                        state_next = (window_reg && cd_dec == '0) ?
                                     sat_pkg::ST_COMPACT : sat_pkg::ST_FINISH;
                    end
                    sat_pkg::OP_REMOVE:
                    begin
                        state_next = bad_idx ? sat_pkg::ST_FINISH : sat_pkg::ST_SHIFT;
                    end
                    default:
                    begin
                        state_next = sat_pkg::ST_FINISH;
                    end
                endcase
            end
            sat_pkg::ST_FIND:
            begin
                if (hit)
                begin
                    state_next = (!replied_reg[proc_reg] && all_answered) ?
                                 sat_pkg::ST_COMPACT : sat_pkg::ST_FINISH;
                end
                else if (ptr_reg == count_reg)
                begin
                    state_next = sat_pkg::ST_FINISH;
                end
            end
            sat_pkg::ST_SHIFT,
            sat_pkg::ST_COMPACT:
            begin
                if (walk_end)
                begin
                    state_next = sat_pkg::ST_FINISH;
                end
            end
            sat_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sat_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and table updates
    always_comb
    begin
        op_next        = op_reg;
        iid_next       = iid_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        window_next    = window_reg;
        countdown_next = countdown_reg;
        replied_next   = replied_reg;
        accepted_next  = accepted_reg;
        ptr_next       = ptr_reg;
        wptr_next      = wptr_reg;
        pend_next      = pend_reg;
        proc_next      = proc_reg;
        acc_next       = acc_reg;
        rej_next       = rej_reg;
        sil_next       = sil_reg;
        rc_next        = rc_reg;
        match_next     = match_reg;
        done_next      = done_reg;
        empty_next     = empty_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = iid_reg;
        ram_raddr      = ptr_reg[AW-1:0];

        case (state_reg)
            sat_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = item.op;
                    iid_next    = item.node_iid;
                    status_next = item.report_status;
                    idx_next    = item.entry_index;
                    ptr_next    = '0;
                    wptr_next   = '0;
                    pend_next   = 1'b0;
                    acc_next    = '0;
                    rej_next    = '0;
                    sil_next    = '0;
                    rc_next     = sat_pkg::RC_OK;
                    match_next  = '0;
                    done_next   = 1'b0;
                    empty_next  = 1'b0;
                end
            end
            sat_pkg::ST_EXEC:
            begin
                case (op_reg)
                    sat_pkg::OP_CLEAR:
                    begin
                        count_next     = '0;
                        window_next    = 1'b0;
                        countdown_next = '0;
                        replied_next   = '0;
                        accepted_next  = '0;
                    end
                    sat_pkg::OP_ADD:
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            rc_next = sat_pkg::RC_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    sat_pkg::OP_BEGIN:
                    begin
                        replied_next   = '0;
                        accepted_next  = '0;
                        window_next    = 1'b1;
                        countdown_next = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
                    end
                    sat_pkg::OP_REPORT:
                    begin
                        if (!window_reg)
                        begin
                            rc_next = sat_pkg::RC_WINDOW;
                        end
                        else if (count_reg == '0)
                        begin
                            rc_next = sat_pkg::RC_UNKNOWN;
                        end
                    end
                    sat_pkg::OP_TICK:
                    begin
                        if (window_reg)
                        begin
                            countdown_next = cd_dec;
                        end
                    end
                    sat_pkg::OP_CANCEL:
                    begin
                        window_next    = 1'b0;
                        countdown_next = '0;
                    end
                    sat_pkg::OP_REMOVE:
                    begin
                        if (bad_idx)
                        begin
                            rc_next = sat_pkg::RC_BADIDX;
                        end
                        else
                        begin
                            // Marks shift in one step; identifiers follow in the walk.
                            for (int j = 0; j < MAX_ENTRIES; j++)
                            begin
                                if (CW'(j) >= idx_cw)
                                begin
                                    replied_next[j]  = rep_shift[j];
                                    accepted_next[j] = acc_shift[j];
                                end
                            end
                            ptr_next = idx_cw + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            sat_pkg::ST_FIND:
            begin
                ptr_next  = issue ? ptr_reg + 1'b1 : ptr_reg;
                pend_next = issue;
                proc_next = ptr_reg[AW-1:0];
                if (hit)
                begin
                    match_next = proc_reg;
                    if (replied_reg[proc_reg])
                    begin
                        rc_next = sat_pkg::RC_DUP;
                    end
                    else
                    begin
                        replied_next[proc_reg]  = 1'b1;
                        accepted_next[proc_reg] = status_reg == accepted_code;
                        if (all_answered)
                        begin
                            // Restart the walk for compaction.
                            ptr_next  = '0;
                            pend_next = 1'b0;
                        end
                    end
                end
                else if (ptr_reg == count_reg)
                begin
                    rc_next = sat_pkg::RC_UNKNOWN;
                end
            end
            sat_pkg::ST_SHIFT:
            begin
                ptr_next  = issue ? ptr_reg + 1'b1 : ptr_reg;
                pend_next = issue;
                proc_next = ptr_reg[AW-1:0];
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(proc_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (walk_end)
                begin
                    count_next = count_reg - 1'b1;
                    empty_next = count_reg == CW'(1);
                end
            end
            sat_pkg::ST_COMPACT:
            begin
                ptr_next  = issue ? ptr_reg + 1'b1 : ptr_reg;
                pend_next = issue;
                proc_next = ptr_reg[AW-1:0];
                if (pend_reg)
                begin
                    if (replied_reg[proc_reg] && accepted_reg[proc_reg])
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wptr_reg[AW-1:0];
                        ram_wdata = ram_rdata;
                        wptr_next = wptr_reg + 1'b1;
                        acc_next  = acc_reg + 1'b1;
                    end
                    else if (replied_reg[proc_reg])
                    begin
                        rej_next = rej_reg + 1'b1;
                    end
                    else
                    begin
                        sil_next = sil_reg + 1'b1;
                    end
                end
                if (walk_end)
                begin
                    count_next     = wptr_reg;
                    replied_next   = keep_mask;
                    accepted_next  = keep_mask;
                    window_next    = 1'b0;
                    countdown_next = '0;
                    done_next      = 1'b1;
                    empty_next     = wptr_reg == '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result outputs
    always_comb
    begin
        idle               = state_reg == sat_pkg::ST_IDLE;
        res_valid          = (state_reg == sat_pkg::ST_FINISH) && out_free;
        res.result_code    = rc_reg;
        res.member_count   = 7'(count_reg);
        res.window_open    = window_reg;
        res.admission_done = done_reg;
        res.accepted_total = 7'(acc_reg);
        res.rejected_total = 7'(rej_reg);
        res.silent_total   = 7'(sil_reg);
        res.table_empty    = empty_reg;
        res.match_index    = 6'(match_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sat_pkg::ST_IDLE;
            count_reg     <= '0;
            window_reg    <= 1'b0;
            countdown_reg <= '0;
            replied_reg   <= '0;
            accepted_reg  <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            window_reg    <= window_next;
            countdown_reg <= countdown_next;
            replied_reg   <= replied_next;
            accepted_reg  <= accepted_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        iid_reg    <= iid_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        wptr_reg   <= wptr_next;
        proc_reg   <= proc_next;
        acc_reg    <= acc_next;
        rej_reg    <= rej_next;
        sil_reg    <= sil_next;
        rc_reg     <= rc_next;
        match_reg  <= match_next;
        done_reg   <= done_next;
        empty_reg  <= empty_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("member count above table size");

    a_marks_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sat_pkg::ST_IDLE |-> ((replied_reg | accepted_reg) & ~valid_mask) == '0)
        else $error("mark set beyond member count");

    a_accept_needs_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accepted_reg & ~replied_reg) == '0)
        else $error("accepted mark without reply mark");

    a_closed_no_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        !window_reg |-> countdown_reg == '0)
        else $error("countdown running while window closed");
`endif

endmodule

`default_nettype wire

// ----- verif/session_admission_table_core_tb.sv -----
// Self-checking testbench for the session admission table core.
`timescale 1ns / 100ps

module session_admission_table_core_tb;

    localparam int DEPTH = 16;
    localparam int QUIET_CYCLES = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STALL_CYCLES = 300;
    localparam sat_pkg::op_t OP_RESERVED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_ready;
    sat_pkg::sat_req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    sat_pkg::sat_rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [sat_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sat_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the block: roster contents, marks, round state and registers.
    logic [63:0] roster_id [DEPTH];
    bit [DEPTH-1:0] roster_replied = '0;
    bit [DEPTH-1:0] roster_accepted = '0;
    int roster_count = 0;
    bit round_open = 1'b0;
    int ticks_left = 0;
    logic [15:0] cfg_timeout = sat_pkg::TIMEOUT_RESET;
    logic [7:0] cfg_accept = sat_pkg::ACCEPT_RESET;

    sat_pkg::sat_rsp_t pending_rsp [$];
    int mismatches = 0;
    int items_sent = 0;
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    int rsp_hold_left = 0;

    session_admission_table_core #(
        .MAX_ENTRIES(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Keep accepting members, drop the rest, report the close totals.
    function automatic void close_round(inout sat_pkg::sat_rsp_t r);
        int i;
        int kept;
        kept = 0;
        r.admission_done = 1'b1;
        for (i = 0; i < roster_count; i++)
        begin
            if (roster_replied[i] && roster_accepted[i])
            begin
                roster_id[kept] = roster_id[i];
                kept++;
                r.accepted_total++;
            end
            else if (roster_replied[i])
                r.rejected_total++;
            else
                r.silent_total++;
        end
        roster_replied = '0;
        roster_accepted = '0;
        for (i = 0; i < kept; i++)
        begin
            roster_replied[i] = 1'b1;
            roster_accepted[i] = 1'b1;
        end
        roster_count = kept;
        round_open = 1'b0;
        ticks_left = 0;
    endfunction

    function automatic sat_pkg::sat_rsp_t next_response(input sat_pkg::sat_req_t item);
        sat_pkg::sat_rsp_t r;
        int i;
        int hit;
        bit all_answered;
        bit closed;
        bit emptied;
        r = '0;
        r.result_code = sat_pkg::RC_OK;
        hit = -1;
        closed = 1'b0;
        emptied = 1'b0;
        case (item.op)
            sat_pkg::OP_CLEAR:
            begin
                roster_count = 0;
                round_open = 1'b0;
                ticks_left = 0;
                roster_replied = '0;
                roster_accepted = '0;
            end
            sat_pkg::OP_ADD:
            begin
                if (roster_count >= DEPTH)
                    r.result_code = sat_pkg::RC_FULL;
                else
                begin
                    roster_id[roster_count] = item.node_iid;
                    roster_replied[roster_count] = 1'b0;
                    roster_accepted[roster_count] = 1'b0;
                    roster_count++;
                end
            end
            sat_pkg::OP_BEGIN:
            begin
                roster_replied = '0;
                roster_accepted = '0;
                round_open = 1'b1;
                ticks_left = (cfg_timeout == 0) ? 1 : cfg_timeout;
            end
            sat_pkg::OP_REPORT:
            begin
                if (!round_open)
                    r.result_code = sat_pkg::RC_WINDOW;
                else
                begin
                    for (i = 0; i < roster_count; i++)
                        if (hit < 0 && roster_id[i] == item.node_iid)
                            hit = i;
                    if (hit < 0)
                        r.result_code = sat_pkg::RC_UNKNOWN;
                    else
                    begin
                        r.match_index = 6'(hit);
                        if (roster_replied[hit])
                            r.result_code = sat_pkg::RC_DUP;
                        else
                        begin
                            roster_replied[hit] = 1'b1;
                            roster_accepted[hit] = (item.report_status == cfg_accept);
                            all_answered = 1'b1;
                            for (i = 0; i < roster_count; i++)
                                if (!roster_replied[i])
                                    all_answered = 1'b0;
                            if (all_answered)
                            begin
                                close_round(r);
                                closed = 1'b1;
                            end
                        end
                    end
                end
            end
            sat_pkg::OP_TICK:
            begin
                if (round_open)
                begin
                    if (ticks_left > 0)
                        ticks_left--;
                    if (ticks_left == 0)
                    begin
                        close_round(r);
                        closed = 1'b1;
                    end
                end
            end
            sat_pkg::OP_CANCEL:
            begin
                round_open = 1'b0;
                ticks_left = 0;
            end
            sat_pkg::OP_REMOVE:
            begin
                if (item.entry_index >= roster_count)
                    r.result_code = sat_pkg::RC_BADIDX;
                else
                begin
                    for (i = item.entry_index + 1; i < roster_count; i++)
                    begin
                        roster_id[i-1] = roster_id[i];
                        roster_replied[i-1] = roster_replied[i];
                        roster_accepted[i-1] = roster_accepted[i];
                    end
                    roster_count--;
                    roster_replied[roster_count] = 1'b0;
                    roster_accepted[roster_count] = 1'b0;
                    if (roster_count == 0)
                        emptied = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (closed && roster_count == 0)
            emptied = 1'b1;
        r.member_count = 7'(roster_count);
        r.window_open = round_open;
        r.table_empty = emptied;
        return r;
    endfunction

    function automatic string rsp_text(input sat_pkg::sat_rsp_t r);
        return $sformatf("rc=%0d cnt=%0d win=%0b done=%0b acc=%0d rej=%0d sil=%0d empty=%0b idx=%0d",
                         r.result_code, r.member_count, r.window_open, r.admission_done,
                         r.accepted_total, r.rejected_total, r.silent_total, r.table_empty,
                         r.match_index);
    endfunction

    function automatic logic [63:0] pick_member_id();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roster_count > 0 && roll < 25)
            return roster_id[$urandom_range(roster_count - 1)];
        if (roll < 30)
            return '0;
        if (roll < 35)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_status();
        if ($urandom_range(99) < 60)
            return cfg_accept;
        return 8'($urandom_range(255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input sat_pkg::op_t op, input logic [63:0] iid,
                             input logic [7:0] status, input logic [5:0] idx);
        sat_pkg::sat_req_t item;
        item.op = op;
        item.node_iid = iid;
        item.report_status = status;
        item.entry_index = idx;
        while (src_idle_en && $urandom_range(99) < 10)
            @(negedge clk);
        req = item;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp.push_back(next_response(item));
        items_sent++;
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic send_op(input sat_pkg::op_t op);
        send_item(op, {$urandom, $urandom}, 8'($urandom_range(255)), 6'($urandom_range(63)));
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [sat_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sat_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == sat_pkg::CFG_TIMEOUT)
            cfg_timeout = data;
        else if (idx == sat_pkg::CFG_ACCEPT_CODE)
            cfg_accept = data[7:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic report_unreplied();
        int slots [$];
        int i;
        for (i = 0; i < roster_count; i++)
            if (!roster_replied[i])
                slots.push_back(i);
        if (slots.size() == 0)
            send_op(sat_pkg::OP_TICK);
        else
            send_item(sat_pkg::OP_REPORT, roster_id[slots[$urandom_range(slots.size() - 1)]],
                      pick_status(), 6'($urandom_range(63)));
    endtask

    // Mostly complete rounds with random content, some noise items in between.
    task automatic run_random_rounds(input int quota);
        int stop_at;
        int steps;
        int unsigned roll;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(sat_pkg::op_t'($urandom_range(7)), {$urandom, $urandom},
                          8'($urandom_range(255)), 6'($urandom_range(63)));
            end
            else
            begin
                if ($urandom_range(1))
                    send_op(sat_pkg::OP_CLEAR);
                repeat ($urandom_range(17))
                    send_item(sat_pkg::OP_ADD, pick_member_id(), 8'($urandom_range(255)),
                              6'($urandom_range(63)));
                send_op(sat_pkg::OP_BEGIN);
                steps = 0;
                while (round_open && steps < 60)
                begin
                    roll = $urandom_range(99);
                    if (roll < 65)
                        report_unreplied();
                    else if (roll < 73 && roster_count > 0)
                        send_item(sat_pkg::OP_REPORT,
                                  roster_id[$urandom_range(roster_count - 1)],
                                  pick_status(), 6'($urandom_range(63)));
                    else if (roll < 77)
                        send_item(sat_pkg::OP_REPORT, {$urandom, $urandom},
                                  8'($urandom_range(255)), 6'($urandom_range(63)));
                    else if (roll < 87)
                        send_op(sat_pkg::OP_TICK);
                    else if (roll < 91)
                        send_item(sat_pkg::OP_REMOVE, {$urandom, $urandom},
                                  8'($urandom_range(255)), 6'($urandom_range(roster_count)));
                    else if (roll < 94)
                        send_item(sat_pkg::OP_ADD, pick_member_id(), 8'($urandom_range(255)),
                                  6'($urandom_range(63)));
                    else if (roll < 96)
                        send_op(sat_pkg::OP_BEGIN);
                    else if (roll < 98)
                        send_op(sat_pkg::OP_CANCEL);
                    else
                        send_op(sat_pkg::OP_CLEAR);
                    steps++;
                end
                // close a stuck round by timeout when near, else abort it
                if (round_open && ticks_left > 24)
                    send_op(sat_pkg::OP_CANCEL);
                while (round_open)
                    send_op(sat_pkg::OP_TICK);
            end
        end
    endtask

    task automatic test_outside_window();
        send_item(sat_pkg::OP_REPORT, '1, 8'hFF, 6'd0);
        send_item(sat_pkg::OP_TICK, '0, 8'h00, 6'd0);
        send_op(sat_pkg::OP_CANCEL);
        send_item(sat_pkg::OP_REMOVE, '0, 8'h00, 6'd63);
        send_op(OP_RESERVED);
    endtask

    task automatic test_admission_flow();
        send_item(sat_pkg::OP_ADD, 64'h0, 8'h00, 6'd0);
        send_item(sat_pkg::OP_ADD, '1, 8'h00, 6'd0);
        send_item(sat_pkg::OP_ADD, '1, 8'h00, 6'd0);
        send_op(sat_pkg::OP_BEGIN);
        send_item(sat_pkg::OP_REPORT, '1, 8'h00, 6'd0);
        send_op(sat_pkg::OP_BEGIN);
        send_item(sat_pkg::OP_REPORT, '1, 8'h00, 6'd0);
        send_item(sat_pkg::OP_REPORT, '1, 8'h00, 6'd0);
        send_item(sat_pkg::OP_REPORT, 64'h1234, 8'h00, 6'd0);
        send_item(sat_pkg::OP_ADD, 64'hA5A5_5A5A_0F0F_F0F0, 8'h00, 6'd0);
        // drop the shadowed copy: the round stays open
        send_item(sat_pkg::OP_REMOVE, '0, 8'h00, 6'd2);
        send_item(sat_pkg::OP_REPORT, 64'h0, 8'hFF, 6'd0);
        send_item(sat_pkg::OP_REPORT, 64'hA5A5_5A5A_0F0F_F0F0, 8'h00, 6'd0);
    endtask

    task automatic test_zero_timeout_close();
        write_reg(sat_pkg::CFG_TIMEOUT, 16'd0);
        write_reg(sat_pkg::CFG_ACCEPT_CODE, 16'hFF00);
        send_op(sat_pkg::OP_BEGIN);
        send_op(sat_pkg::OP_TICK);
        send_item(sat_pkg::OP_ADD, {$urandom, $urandom}, 8'h00, 6'd0);
        send_item(sat_pkg::OP_REMOVE, '0, 8'h00, 6'd0);
        send_op(sat_pkg::OP_BEGIN);
        send_op(sat_pkg::OP_CLEAR);
        write_reg(sat_pkg::CFG_TIMEOUT, sat_pkg::TIMEOUT_RESET);
        write_reg(sat_pkg::CFG_ACCEPT_CODE, 16'(sat_pkg::ACCEPT_RESET));
    endtask

    task automatic test_config_sweep();
        write_reg(sat_pkg::CFG_TIMEOUT, 16'd1);
        write_reg(sat_pkg::CFG_ACCEPT_CODE, 16'h00FF);
        run_random_rounds(350);
        write_reg(sat_pkg::CFG_TIMEOUT, 16'hFFFF);
        write_reg(sat_pkg::CFG_ACCEPT_CODE, 16'($urandom_range(65535)));
        run_random_rounds(350);
        write_reg(sat_pkg::CFG_TIMEOUT, 16'($urandom_range(12, 2)));
        write_reg(sat_pkg::CFG_ACCEPT_CODE, 16'h0000);
        run_random_rounds(350);
    endtask

    task automatic test_back_to_back();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        run_random_rounds(300);
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_stalled_receiver();
        rsp_hold_left = STALL_CYCLES;
        run_random_rounds(40);
    endtask

    task automatic test_sender_pause();
        wait_drained();
        run_random_rounds(40);
    endtask

    // Receiver: random backpressure, or a counted hold when one is requested.
    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_ready = 1'b0;
            rsp_hold_left--;
        end
        else
            rsp_ready = !(sink_idle_en && $urandom_range(99) < 10);
    end

    always @(posedge clk)
    begin : check_rsp
        sat_pkg::sat_rsp_t want;
        bit bad;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: %s", rsp_text(rsp));
            end
            else
            begin
                want = pending_rsp.pop_front();
                bad = (rsp.result_code !== want.result_code)
                   || (rsp.member_count !== want.member_count)
                   || (rsp.window_open !== want.window_open)
                   || (rsp.admission_done !== want.admission_done)
                   || (rsp.accepted_total !== want.accepted_total)
                   || (rsp.rejected_total !== want.rejected_total)
                   || (rsp.silent_total !== want.silent_total)
                   || (rsp.table_empty !== want.table_empty)
                   || (rsp.match_index !== want.match_index);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: want %s", $realtime, rsp_text(want));
                        $display("                 got  %s", rsp_text(rsp));
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : run_tests
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_outside_window();
        test_admission_flow();
        test_zero_timeout_close();
        run_random_rounds(400);
        test_config_sweep();
        test_back_to_back();
        test_stalled_receiver();
        test_sender_pause();
        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
